FILE: src/etpr_pkg.sv
`default_nettype none

package etpr_pkg;

  // Sample and fraction formats.
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 16;

  // Envelope scale: the sum of two magnitudes reaches 2^SAMPLE_BITS.
  localparam int LEVEL_W   = SAMPLE_BITS + 1;
  // Tune and use: Q0.FRAC_BITS with room for exactly 1.0.
  localparam int TUNE_W    = FRAC_BITS + 1;
  localparam int THR_W     = 17;
  localparam int STEP_W    = 17;
  localparam int COEF_W    = 17;
  localparam int WHAMMY_W  = 7;
  localparam int RATIO_W   = 20;
  localparam int MODE_W    = 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [TUNE_W-1:0] ONE_Q = TUNE_W'(1) << FRAC_BITS;

  // Shared multiplier geometry.
  localparam int MUL_W  = 24;
  localparam int PROD_W = 2 * MUL_W;

  // Division by 127 through a reciprocal: floor(x / 127) equals
  // (x * RECIP_127) >> RECIP_SHIFT for every x below 8729608, which covers
  // the largest rounded whammy product.
  localparam logic [MUL_W-1:0] RECIP_127   = 24'd8454661;
  localparam int               RECIP_SHIFT = 30;
  localparam logic [MUL_W-1:0] ROUND_127   = 24'd63;

  typedef enum logic [MODE_W-1:0] {
    MODE_ENV    = 2'd0,
    MODE_WHAMMY = 2'd1,
    MODE_INV    = 2'd2,
    MODE_RSVD   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_UP   = 2'd1,
    PH_WAIT = 2'd2,
    PH_DOWN = 2'd3
  } ramp_phase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE      = 3'd0,
    REG_THRESHOLD = 3'd1,
    REG_ATTACK    = 3'd2,
    REG_DECAY     = 3'd3,
    REG_RELEASE   = 3'd4,
    REG_WHAMMY    = 3'd5,
    REG_RANGE     = 3'd6,
    REG_INTERVAL  = 3'd7
  } cfg_reg_e;

  typedef enum logic [2:0] {
    SQ_IDLE  = 3'd0,
    SQ_ENV_A = 3'd1,
    SQ_ENV_B = 3'd2,
    SQ_TRACK = 3'd3,
    SQ_SCALE = 3'd4,
    SQ_DIV   = 3'd5,
    SQ_RATIO = 3'd6,
    SQ_DONE  = 3'd7
  } seq_e;

endpackage

`default_nettype wire

FILE: src/envelope_triggered_pitch_ramp_top.sv
`default_nettype none

// Envelope-triggered pitch ramp. Each item is one stereo sample pair; each
// item yields one result with the mono mix, the tune ramp value after this
// sample, the ramp phase and the pitch ratio 1 + (range - 1) * use in Q4.16.
// All multiplications run through one registered 24x24 multiplier that a
// small sequencer steps through: release blend (two products), whammy
// scaling, division by 127 via a reciprocal, and the ratio product. In the
// envelope modes (0 and 2) an item steps through ENV_A, ENV_B, TRACK, SCALE,
// DIV, RATIO and DONE; in modes 1 and 3 the envelope steps are skipped and
// an item goes straight to SCALE. No new item is accepted until the last
// one leaves DONE; a finished result sits in an output register, and the
// next item is accepted while it waits. The configuration port is always
// ready and should be written only while the block is idle.
module envelope_triggered_pitch_ramp_top (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [etpr_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [etpr_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [etpr_pkg::SAMPLE_BITS-1:0] left_sample_i,
  input  logic signed [etpr_pkg::SAMPLE_BITS-1:0] right_sample_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [etpr_pkg::SAMPLE_BITS-1:0] mono_sample_o,
  output logic [etpr_pkg::TUNE_W-1:0]            tune_level_o,
  output logic [1:0]                             ramp_phase_o,
  output logic [etpr_pkg::RATIO_W-1:0]           pitch_ratio_o
);
  import etpr_pkg::*;

  // Configuration registers.
  mode_e               mode_q;
  logic [THR_W-1:0]    thr_q;
  logic [STEP_W-1:0]   attack_q;
  logic [STEP_W-1:0]   decay_q;
  logic [COEF_W-1:0]   release_q;
  logic [WHAMMY_W-1:0] whammy_q;
  logic [RATIO_W-1:0]  range_q;
  logic                iz_q;

  // Sequencer and tracking state.
  seq_e                state_q, state_d;
  logic [LEVEL_W-1:0]  env_q;
  ramp_phase_e         phase_q;
  logic [TUNE_W-1:0]   tune_q;

  // Per-item working registers.
  logic [LEVEL_W-1:0]          sum_q;
  logic signed [SAMPLE_BITS-1:0] mono_q;
  logic [2*LEVEL_W-2:0]        acc_q;
  logic [TUNE_W-1:0]           use_q;

  // Result register.
  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_mono_q;
  logic [TUNE_W-1:0]             out_tune_q;
  ramp_phase_e                   out_phase_q;
  logic [RATIO_W-1:0]            out_ratio_q;

  // Shared multiplier connections.
  logic              mul_en;
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod;

  logic                  in_fire;
  logic                  out_load;
  logic                  tracking;
  logic [COEF_W-1:0]     c_sat;
  logic [LEVEL_W-1:0]    sum_n;
  logic signed [SAMPLE_BITS-1:0] mono_n;
  logic [MUL_W-1:0]      div_x;
  logic [TUNE_W-1:0]     quot;
  logic [TUNE_W-1:0]     use_n;
  logic [RATIO_W:0]      ratio_n;
  logic [LEVEL_W-1:0]    env_n;
  ramp_phase_e           phase_n;
  logic [TUNE_W-1:0]     tune_n;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == SQ_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_load    = (state_q == SQ_DONE) && (!out_valid_q || out_ready_i);
  assign tracking    = (mode_q == MODE_ENV) || (mode_q == MODE_INV);

  // The release weight saturates at 1.0.
  assign c_sat = (release_q > COEF_W'(ONE_Q)) ? COEF_W'(ONE_Q) : release_q;

  // Magnitude sum and mono mix straight from the accepted sample pair. The
  // floored half of a 17-bit sum always fits the sample range, so no clamp
  // is needed.
  always_comb begin
    logic signed [LEVEL_W-1:0] l_ext, r_ext, abs_l, abs_r, lr_sum;
    l_ext  = LEVEL_W'(left_sample_i);
    r_ext  = LEVEL_W'(right_sample_i);
    abs_l  = l_ext[LEVEL_W-1] ? -l_ext : l_ext;
    abs_r  = r_ext[LEVEL_W-1] ? -r_ext : r_ext;
    sum_n  = LEVEL_W'(abs_l) + LEVEL_W'(abs_r);
    lr_sum = l_ext + r_ext;
    mono_n = lr_sum[LEVEL_W-1:1];
  end

  // Envelope, phase and tune update for one sample, applied in order.
  always_comb begin
    logic [2*LEVEL_W-1:0] blend;
    logic [THR_W+1:0]     t3;
    logic [TUNE_W+1:0]    tn;
    blend   = {1'b0, acc_q} + (2*LEVEL_W)'(prod[2*LEVEL_W-2:0]);
    env_n   = (sum_q > env_q) ? sum_q : blend[FRAC_BITS +: LEVEL_W];
    t3      = ((THR_W+2)'(thr_q) + (THR_W+2)'({thr_q, 1'b0})) >> 2;
    phase_n = phase_q;
    tn      = (TUNE_W+2)'(tune_q);
    if (env_n <= LEVEL_W'(thr_q >> 1)) begin
      phase_n = PH_IDLE;
      tn      = '0;
    end
    if (phase_n == PH_IDLE && env_n >= LEVEL_W'(thr_q)) begin
      phase_n = PH_UP;
    end
    if (phase_n == PH_UP) begin
      tn = tn + (TUNE_W+2)'(attack_q);
      if (tn >= (TUNE_W+2)'(ONE_Q)) begin
        phase_n = PH_WAIT;
      end
    end
    if (phase_n == PH_WAIT) begin
      tn = (TUNE_W+2)'(ONE_Q);
      if ((THR_W+2)'(env_n) < t3) begin
        phase_n = PH_DOWN;
      end
    end
    if (phase_n == PH_DOWN) begin
      if (tn <= (TUNE_W+2)'(decay_q)) begin
        tn      = '0;
        phase_n = PH_IDLE;
      end else begin
        tn = tn - (TUNE_W+2)'(decay_q);
      end
    end
    tune_n = tn[TUNE_W-1:0];
  end

  // Dividend for the rounded division by 127: whammy alone in mode 1,
  // tune times whammy otherwise.
  assign div_x = (mode_q == MODE_WHAMMY)
               ? MUL_W'({whammy_q, {FRAC_BITS{1'b0}}}) + ROUND_127
               : MUL_W'(prod[TUNE_W+WHAMMY_W-1:0]) + ROUND_127;
  assign quot  = prod[RECIP_SHIFT +: TUNE_W];

  always_comb begin
    case (mode_q)
      MODE_WHAMMY: use_n = quot;
      MODE_ENV:    use_n = iz_q ? quot : tune_q;
      MODE_INV:    use_n = ONE_Q - tune_q;
      default:     use_n = tune_q;
    endcase
  end

  // ratio = 1 - use + range * use, the last term truncated.
  assign ratio_n = (RATIO_W+1)'(ONE_Q) - (RATIO_W+1)'(use_q)
                 + (RATIO_W+1)'(prod[FRAC_BITS +: RATIO_W]);

  // Sequencer: next state and multiplier operands.
  always_comb begin
    state_d = state_q;
    mul_en  = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    case (state_q)
      SQ_IDLE: begin
        if (in_fire) begin
          state_d = tracking ? SQ_ENV_A : SQ_SCALE;
        end
      end
      SQ_ENV_A: begin
        mul_en  = 1'b1;
        mul_a   = MUL_W'(sum_q);
        mul_b   = MUL_W'(c_sat);
        state_d = SQ_ENV_B;
      end
      SQ_ENV_B: begin
        mul_en  = 1'b1;
        mul_a   = MUL_W'(env_q);
        mul_b   = MUL_W'(COEF_W'(ONE_Q) - c_sat);
        state_d = SQ_TRACK;
      end
      SQ_TRACK: begin
        state_d = SQ_SCALE;
      end
      SQ_SCALE: begin
        mul_en  = 1'b1;
        mul_a   = MUL_W'(tune_q);
        mul_b   = MUL_W'(whammy_q);
        state_d = SQ_DIV;
      end
      SQ_DIV: begin
        mul_en  = 1'b1;
        mul_a   = div_x;
        mul_b   = RECIP_127;
        state_d = SQ_RATIO;
      end
      SQ_RATIO: begin
        mul_en  = 1'b1;
        mul_a   = MUL_W'(use_n);
        mul_b   = MUL_W'(range_q);
        state_d = SQ_DONE;
      end
      SQ_DONE: begin
        if (out_load) begin
          state_d = SQ_IDLE;
        end
      end
      default: state_d = SQ_IDLE;
    endcase
  end

  etpr_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // Control state, configuration and tracking state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SQ_IDLE;
      out_valid_q <= 1'b0;
      mode_q      <= MODE_ENV;
      thr_q       <= 17'd6554;
      attack_q    <= 17'd114;
      decay_q     <= 17'd114;
      release_q   <= 17'd655;
      whammy_q    <= '0;
      range_q     <= RATIO_W'(ONE_Q);
      iz_q        <= 1'b1;
      env_q       <= '0;
      phase_q     <= PH_IDLE;
      tune_q      <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == SQ_TRACK) begin
        env_q   <= env_n;
        phase_q <= phase_n;
        tune_q  <= tune_n;
      end
      if (cfg_valid_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_MODE:      mode_q    <= mode_e'(cfg_data_i[MODE_W-1:0]);
          REG_THRESHOLD: thr_q     <= cfg_data_i[THR_W-1:0];
          REG_ATTACK:    attack_q  <= cfg_data_i[STEP_W-1:0];
          REG_DECAY:     decay_q   <= cfg_data_i[STEP_W-1:0];
          REG_RELEASE:   release_q <= cfg_data_i[COEF_W-1:0];
          REG_WHAMMY:    whammy_q  <= cfg_data_i[WHAMMY_W-1:0];
          REG_RANGE:     range_q   <= cfg_data_i[RATIO_W-1:0];
          REG_INTERVAL:  iz_q      <= cfg_data_i[0];
          default:       ;
        endcase
      end
    end
  end

  // Working and result payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sum_q  <= sum_n;
      mono_q <= mono_n;
    end
    if (state_q == SQ_ENV_B) begin
      acc_q <= prod[2*LEVEL_W-2:0];
    end
    if (state_q == SQ_RATIO) begin
      use_q <= use_n;
    end
    if (out_load) begin
      out_mono_q  <= mono_q;
      out_tune_q  <= tune_q;
      out_phase_q <= phase_q;
      out_ratio_q <= ratio_n[RATIO_W-1:0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign mono_sample_o = out_mono_q;
  assign tune_level_o  = out_tune_q;
  assign ramp_phase_o  = out_phase_q;
  assign pitch_ratio_o = out_ratio_q;

  // The tune ramp never leaves [0, 1.0].
  a_tune_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tune_q <= ONE_Q)
    else $error("tune above 1.0");

  // An idle ramp always rests at zero tune.
  a_idle_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> (tune_q == '0))
    else $error("idle phase with nonzero tune");

  // Holding means the tune sits at exactly 1.0; rising means below it.
  a_wait_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((phase_q == PH_WAIT) |-> (tune_q == ONE_Q)) and
    ((phase_q == PH_UP) |-> (tune_q < ONE_Q)))
    else $error("tune inconsistent with phase");

  // The envelope stays on the sample-sum scale.
  a_env_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    env_q <= (LEVEL_W'(1) << SAMPLE_BITS))
    else $error("envelope out of range");

  // An accepted item keeps the block busy in the following cycle.
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("ready right after accept");

endmodule

`default_nettype wire

FILE: src/etpr_mul.sv
`default_nettype none

module etpr_mul (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [etpr_pkg::MUL_W-1:0]  a_i,
  input  logic [etpr_pkg::MUL_W-1:0]  b_i,
  output logic [etpr_pkg::PROD_W-1:0] p_o
);
  import etpr_pkg::*;

  logic [PROD_W-1:0] p_q;

  // Product register; it holds its value while the unit is not in use.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= PROD_W'(a_i) * PROD_W'(b_i);
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire
